>>> sv/line_rasterizer_top_macros.svh
// Assertion macros used by the line rasterizer checker.
`ifndef LINE_RASTERIZER_TOP_MACROS_SVH
`define LINE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define LR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lr_pkg.sv
// Shared types and constants of the line rasterizer.
package lr_pkg;

  // Most pixels emitted for one line request.
  localparam int MAX_PIXELS = 64;
  // Width of the remaining-pixel counter (holds MAX_PIXELS - 1).
  localparam int CNT_BITS   = $clog2(MAX_PIXELS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the request beat
    logic delta;  // compute deltas and step directions
    logic init;   // set start pixel, error terms and pixel count
    logic step;   // advance to the next pixel
  } lr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;   // the current pixel is the final one of the line
  } lr_status_t;

endpackage

>>> sv/lr_if.sv
// Channel interfaces: line request and pixel output.
interface lr_req_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [15:0]           line_color;

  modport source (
    output valid, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

interface lr_pix_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [15:0]           pixel_color;
  logic                  last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

>>> sv/lr_ctrl.sv
// Controller state machine of the line rasterizer.
module lr_ctrl
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  input  lr_status_t status,
  output logic       in_ready,
  output logic       out_valid,
  output lr_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DELTA = 4'b0010,
    S_INIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_DELTA;
      S_DELTA: state_next = S_INIT;
      S_INIT:  state_next = S_EMIT;
      S_EMIT:  if (out_ready && status.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake and datapath commands.
  always_comb begin
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_EMIT);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.delta  = (state == S_DELTA);
    cmd.init   = (state == S_INIT);
    cmd.step   = (state == S_EMIT) && out_ready && !status.last;
  end

endmodule

>>> sv/lr_datapath.sv
// Datapath of the line rasterizer: deltas, error terms and pixel stepping.
module lr_datapath
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  lr_cmd_t               cmd,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [15:0]           line_color,
  output lr_status_t            status,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [15:0]           pixel_color,
  output logic                  last_pixel
);

  localparam int NW = COORD_BITS + 1;

  // Request and setup registers.
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [15:0]           color;
  logic                  xneg, yneg, vert, horz;
  logic [COORD_BITS-1:0] adx, ady, major_len;
  // Walk registers.
  logic [COORD_BITS-1:0] px, py, xerr, yerr;
  logic [CNT_BITS-1:0]   remain;

  // Delta stage values.
  logic                  xneg_d, yneg_d;
  logic [COORD_BITS-1:0] adx_d, ady_d;
  // Init stage values.
  logic [COORD_BITS-1:0] mx, span;
  logic [NW-1:0]         count;
  logic [CNT_BITS-1:0]   remain_init;
  logic [COORD_BITS-1:0] px_init, py_init;
  // Step stage values.
  logic [NW-1:0]         xsum, ysum;
  logic                  xover, yover;
  logic [COORD_BITS-1:0] xerr_next, yerr_next, px_next, py_next;

  // Absolute deltas and step directions.
  always_comb begin
    xneg_d = (ex < sx);
    yneg_d = (ey < sy);
    adx_d  = xneg_d ? (sx - ex) : (ex - sx);
    ady_d  = yneg_d ? (sy - ey) : (ey - sy);
  end

  // Major length, pixel count capped at the line limit, and start pixel.
  always_comb begin
    mx    = (adx > ady) ? adx : ady;
    span  = vert ? ady : (horz ? adx : mx);
    count = {1'b0, span} + ((vert || horz) ? NW'(1) : NW'(2));
    if (count > NW'(MAX_PIXELS)) begin
      remain_init = CNT_BITS'(MAX_PIXELS - 1);
    end else begin
      remain_init = count[CNT_BITS-1:0] - CNT_BITS'(1);
    end
    px_init = sx;
    py_init = sy;
    if (vert) begin
      py_init = yneg ? ey : sy;
    end else if (horz) begin
      px_init = xneg ? ex : sx;
    end
  end

  // Next pixel: straight walk for axis lines, error terms otherwise.
  always_comb begin
    xsum      = {1'b0, xerr} + {1'b0, adx};
    ysum      = {1'b0, yerr} + {1'b0, ady};
    xover     = (xsum > {1'b0, major_len});
    yover     = (ysum > {1'b0, major_len});
    xerr_next = xover ? COORD_BITS'(xsum - {1'b0, major_len}) : xsum[COORD_BITS-1:0];
    yerr_next = yover ? COORD_BITS'(ysum - {1'b0, major_len}) : ysum[COORD_BITS-1:0];
    px_next   = px;
    py_next   = py;
    if (vert) begin
      py_next = py + COORD_BITS'(1);
    end else if (horz) begin
      px_next = px + COORD_BITS'(1);
    end else begin
      if (xover) px_next = xneg ? (px - COORD_BITS'(1)) : (px + COORD_BITS'(1));
      if (yover) py_next = yneg ? (py - COORD_BITS'(1)) : (py + COORD_BITS'(1));
    end
  end

  // Datapath registers, updated by controller command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx    <= start_x;
      sy    <= start_y;
      ex    <= end_x;
      ey    <= end_y;
      color <= line_color;
    end
    if (cmd.delta) begin
      xneg <= xneg_d;
      yneg <= yneg_d;
      adx  <= adx_d;
      ady  <= ady_d;
      vert <= (sx == ex);
      horz <= (sy == ey);
    end
    if (cmd.init) begin
      major_len <= mx;
      px        <= px_init;
      py        <= py_init;
      xerr      <= '0;
      yerr      <= '0;
      remain    <= remain_init;
    end
    if (cmd.step) begin
      px     <= px_next;
      py     <= py_next;
      xerr   <= xerr_next;
      yerr   <= yerr_next;
      remain <= remain - CNT_BITS'(1);
    end
  end

  // Pixel beat and status.
  assign status.last  = (remain == '0);
  assign pixel_x      = px;
  assign pixel_y      = py;
  assign pixel_color  = color;
  assign last_pixel   = (remain == '0);

endmodule

>>> sv/line_rasterizer_top.sv
// Line rasterizer: turns one line request into a stream of pixel beats.
//
// Channels: req carries one line request (two endpoints and a color);
// pix carries one pixel per beat with its coordinates, the request color
// and last_pixel, which is high on the final pixel of the line.
// A vertical or horizontal line walks from its smaller to its larger
// coordinate; any other line steps from the first endpoint with two
// error terms, so its first pixel comes out twice. A line gives at most
// 64 pixels and is cut after the 64th in drawing order.
// After the request beat the controller passes through the delta and init
// setup states, then raises pix.valid with the first pixel beat.
// Throughput: one pixel per cycle while pix.ready is high; the next request
// is taken only after the last pixel beat of the line has been accepted.
// The block holds one line at a time: req.ready is high only when idle.
// A pixel beat is held stable while pix.ready is low, and the walk stops.
// Reset (rst, synchronous) returns the controller to idle with no pixel
// pending; the datapath registers are loaded by each request.
module line_rasterizer_top
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic     clk,
  input  logic     rst,
  lr_req_if.sink   req,
  lr_pix_if.source pix
);

  lr_cmd_t    cmd;
  lr_status_t status;

  // Sequencing of load, setup and pixel walk.
  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (pix.ready),
    .status    (status),
    .in_ready  (req.ready),
    .out_valid (pix.valid),
    .cmd       (cmd)
  );

  // Arithmetic and pixel registers.
  lr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .start_x     (req.start_x),
    .start_y     (req.start_y),
    .end_x       (req.end_x),
    .end_y       (req.end_y),
    .line_color  (req.line_color),
    .status      (status),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .pixel_color (pix.pixel_color),
    .last_pixel  (pix.last_pixel)
  );

endmodule

>>> sv/lr_checker.sv
// Port-level checker of the line rasterizer, bound to the top level.
`include "line_rasterizer_top_macros.svh"

module lr_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  pix_valid,
  input logic                  pix_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic [15:0]           pixel_color,
  input logic                  last_pixel
);

  // One line at a time: no request is taken while a pixel is offered.
  `LR_ASSERT_SAME(a_one_line, pix_valid, !req_ready, "request ready while pixel pending")

  // A request beat starts setup, so ready drops right after it.
  `LR_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready held after request")

  // Once the last pixel is taken, no further pixel follows at once.
  `LR_ASSERT_NEXT(a_end_of_line, pix_valid && pix_ready && last_pixel, !pix_valid, "pixel after last")

  // Within a line the next pixel follows at once with the same color.
  `LR_ASSERT_NEXT(a_line_color, pix_valid && pix_ready && !last_pixel, pix_valid && $stable(pixel_color), "color changed mid-line")

  // A stalled pixel beat holds its coordinates.
  `LR_ASSERT_NEXT(a_stall_hold, pix_valid && !pix_ready, pix_valid && $stable(pixel_x) && $stable(pixel_y), "stalled pixel changed")

endmodule

bind line_rasterizer_top lr_checker #(
  .COORD_BITS (COORD_BITS)
) u_lr_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .pixel_x     (pix.pixel_x),
  .pixel_y     (pix.pixel_y),
  .pixel_color (pix.pixel_color),
  .last_pixel  (pix.last_pixel)
);

>>> bench/tb_top.sv
// Self-checking bench for the line rasterizer: directed and random line requests.
`timescale 1ns / 1ps

module tb_top;
  import lr_pkg::*;

  localparam int COORD_BITS   = 10;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int DRAIN_CYCLES = 20000;
  localparam int TAIL_CYCLES  = 10;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One line request as it travels on the request channel.
  typedef struct packed {
    coord_t      x0;
    coord_t      y0;
    coord_t      x1;
    coord_t      y1;
    logic [15:0] color;
  } line_t;

  // One pixel as it should appear on the pixel channel.
  typedef struct packed {
    coord_t      x;
    coord_t      y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;

  int     send_idle_pct = 16;
  int     recv_idle_pct = 45;
  int     mismatch_count = 0;
  pixel_t pixel_queue[$];

  lr_req_if #(.COORD_BITS(COORD_BITS)) req ();
  lr_pix_if #(.COORD_BITS(COORD_BITS)) pix ();

  line_rasterizer_top #(.COORD_BITS(COORD_BITS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .pix (pix.source)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Appends one expected pixel to the queue.
  function automatic void push_pixel(input coord_t x, input coord_t y,
                                     input logic [15:0] color);
    pixel_t p;
    p.x     = x;
    p.y     = y;
    p.color = color;
    p.last  = 1'b0;
    pixel_queue.push_back(p);
  endfunction

  // Works out the pixel stream of one accepted line request.
  function automatic void rasterize_line(input line_t ln);
    int     n;
    int     lo;
    int     len;
    int     adx;
    int     ady;
    int     major_len;
    int     xerr;
    int     yerr;
    bit     xneg;
    bit     yneg;
    coord_t px;
    coord_t py;
    n = 0;
    if (ln.x0 == ln.x1) begin
      // Vertical line or single point: walk up from the smaller y.
      lo  = (ln.y0 < ln.y1) ? ln.y0 : ln.y1;
      len = (ln.y0 < ln.y1) ? ln.y1 - ln.y0 : ln.y0 - ln.y1;
      for (int i = 0; i <= len && n < MAX_PIXELS; i++) begin
        push_pixel(ln.x0, coord_t'(lo + i), ln.color);
        n++;
      end
    end else if (ln.y0 == ln.y1) begin
      // Horizontal line: walk right from the smaller x.
      lo  = (ln.x0 < ln.x1) ? ln.x0 : ln.x1;
      len = (ln.x0 < ln.x1) ? ln.x1 - ln.x0 : ln.x0 - ln.x1;
      for (int i = 0; i <= len && n < MAX_PIXELS; i++) begin
        push_pixel(coord_t'(lo + i), ln.y0, ln.color);
        n++;
      end
    end else begin
      // Sloped line: two error terms, first pixel comes out twice.
      xneg      = ln.x1 < ln.x0;
      yneg      = ln.y1 < ln.y0;
      adx       = xneg ? ln.x0 - ln.x1 : ln.x1 - ln.x0;
      ady       = yneg ? ln.y0 - ln.y1 : ln.y1 - ln.y0;
      major_len = (adx > ady) ? adx : ady;
      px        = ln.x0;
      py        = ln.y0;
      xerr      = 0;
      yerr      = 0;
      for (int i = 0; i <= major_len + 1 && n < MAX_PIXELS; i++) begin
        push_pixel(px, py, ln.color);
        n++;
        xerr += adx;
        yerr += ady;
        if (xerr > major_len) begin
          xerr -= major_len;
          px = xneg ? px - 1'b1 : px + 1'b1;
        end
        if (yerr > major_len) begin
          yerr -= major_len;
          py = yneg ? py - 1'b1 : py + 1'b1;
        end
      end
    end
    if (n > 0)
      pixel_queue[pixel_queue.size() - 1].last = 1'b1;
  endfunction

  function automatic line_t make_line(input int x0, input int y0, input int x1,
                                      input int y1, input int color);
    line_t ln;
    ln.x0    = coord_t'(x0);
    ln.y0    = coord_t'(y0);
    ln.x1    = coord_t'(x1);
    ln.y1    = coord_t'(y1);
    ln.color = color[15:0];
    return ln;
  endfunction

  // Random coordinate with extra weight on the edges of the range.
  function automatic int random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      return 0;
    else if (pick < 20)
      return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  // Coordinate within span of c, clamped to the legal range.
  function automatic int near_coord(input int c, input int span);
    int v;
    v = c + int'($urandom_range(2 * span)) - span;
    if (v < 0)
      v = 0;
    if (v > COORD_MAX)
      v = COORD_MAX;
    return v;
  endfunction

  // Mostly short lines of every kind, with some full-range ones.
  function automatic line_t random_line();
    int kind;
    int x0;
    int y0;
    int x1;
    int y1;
    kind = $urandom_range(99);
    x0   = random_coord();
    y0   = random_coord();
    if (kind < 15) begin
      x1 = x0;
      y1 = near_coord(y0, 70);
    end else if (kind < 30) begin
      x1 = near_coord(x0, 70);
      y1 = y0;
    end else if (kind < 85) begin
      x1 = near_coord(x0, 48);
      y1 = near_coord(y0, 48);
    end else begin
      x1 = random_coord();
      y1 = random_coord();
    end
    return make_line(x0, y0, x1, y1, int'($urandom_range(16'hFFFF)));
  endfunction

  // Sends one request beat, with random idle cycles ahead of it.
  // Called and returns at a falling edge.
  task automatic send_line(input line_t ln);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid      = 1'b1;
    req.start_x    = ln.x0;
    req.start_y    = ln.y0;
    req.end_x      = ln.x1;
    req.end_y      = ln.y1;
    req.line_color = ln.color;
    @(posedge clk);
    while (!req.ready)
      @(posedge clk);
    rasterize_line(ln);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  // Waits, with a limit, until every expected pixel has arrived.
  task automatic wait_for_pixels();
    int waited;
    waited = 0;
    while (pixel_queue.size() != 0 && waited < DRAIN_CYCLES) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Single points, including both corners of the coordinate range.
  task automatic test_points();
    send_line(make_line(0, 0, 0, 0, 16'h0000));
    send_line(make_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF));
    send_line(make_line(512, 341, 512, 341, 16'hAAAA));
  endtask

  // Vertical and horizontal lines drawn in both directions.
  task automatic test_axis_lines();
    send_line(make_line(5, 10, 5, 20, 16'h5555));
    send_line(make_line(COORD_MAX, COORD_MAX, COORD_MAX, 1000, 16'hF800));
    send_line(make_line(0, 7, 12, 7, 16'h07E0));
    send_line(make_line(COORD_MAX, 0, 990, 0, 16'h001F));
  endtask

  // Shallow and steep sloped lines in four octants, plus exact diagonals in all four directions.
  task automatic test_sloped_lines();
    send_line(make_line(100, 100, 110, 103, 16'h1234));
    send_line(make_line(100, 100, 103, 110, 16'h4321));
    send_line(make_line(100, 100, 90, 97, 16'hBEEF));
    send_line(make_line(100, 100, 97, 90, 16'hCAFE));
    send_line(make_line(100, 100, 110, 90, 16'h0F0F));
    send_line(make_line(100, 100, 90, 110, 16'hF0F0));
    send_line(make_line(200, 200, 210, 210, 16'h8001));
    send_line(make_line(200, 200, 190, 190, 16'h7FFE));
    send_line(make_line(50, 50, 51, 51, 16'hFFFF));
  endtask

  // Lines at and beyond the pixel cap.
  task automatic test_long_lines();
    send_line(make_line(0, 0, 0, COORD_MAX, 16'h0001));
    send_line(make_line(COORD_MAX, 5, 0, 5, 16'h8000));
    send_line(make_line(0, COORD_MAX, COORD_MAX, 0, 16'h5A5A));
    send_line(make_line(0, 0, COORD_MAX, 1, 16'hA5A5));
    send_line(make_line(0, 1, MAX_PIXELS - 1, 1, 16'h3C3C));
    send_line(make_line(0, 2, MAX_PIXELS, 2, 16'hC3C3));
    send_line(make_line(300, 300, 300 + MAX_PIXELS - 2, 320, 16'h6666));
  endtask

  // The sender holds off until the pixel channel has drained.
  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++)
      send_line(random_line());
    wait_for_pixels();
    repeat ($urandom_range(8, 1)) @(negedge clk);
    for (int i = 0; i < 4; i++)
      send_line(random_line());
  endtask

  task automatic test_random_lines(input int count);
    for (int i = 0; i < count; i++)
      send_line(random_line());
  endtask

  // Receiver side: random back-pressure on the pixel channel.
  initial begin
    pix.ready = 1'b0;
    forever begin
      @(negedge clk);
      pix.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each pixel beat against the oldest expected pixel.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && pix.valid && pix.ready) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d) color %h last %b",
                                  pix.pixel_x, pix.pixel_y, pix.pixel_color,
                                  pix.last_pixel));
      end else begin
        want = pixel_queue.pop_front();
        if (pix.pixel_x !== want.x || pix.pixel_y !== want.y ||
            pix.pixel_color !== want.color || pix.last_pixel !== want.last) begin
          report_mismatch($sformatf(
            "got (%0d,%0d) color %h last %b, want (%0d,%0d) color %h last %b",
            pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel,
            want.x, want.y, want.color, want.last));
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.start_x    = '0;
    req.start_y    = '0;
    req.end_x      = '0;
    req.end_y      = '0;
    req.line_color = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sender idles lightly, receiver stalls often.
    send_idle_pct = 16;
    recv_idle_pct = 45;
    test_points();
    test_axis_lines();
    test_sloped_lines();
    test_long_lines();
    test_drain_pause();
    test_random_lines(110);

    // Sender idles often, receiver stalls lightly.
    send_idle_pct = 45;
    recv_idle_pct = 16;
    test_random_lines(120);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(120);

    wait_for_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_queue.size() != 0)
      report_mismatch($sformatf("%0d expected pixels never arrived",
                                pixel_queue.size()));

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> line_rasterizer_top.f
+incdir+sv
sv/lr_pkg.sv
sv/lr_if.sv
sv/lr_ctrl.sv
sv/lr_datapath.sv
sv/line_rasterizer_top.sv
sv/lr_checker.sv
bench/tb_top.sv
